// ===== hdl/msbm_pkg.sv =====
// ----------------------------------------------------------------------------
// msbm_pkg : shared types and constants for the multi-stack block mover
// Transaction payloads, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package msbm_pkg;

    localparam int STACK_COUNT_DEF = 9;
    localparam int STACK_DEPTH_DEF = 64;

    // fixed field widths
    localparam int IDX_W   = 4;
    localparam int COUNT_W = 7;
    localparam int BYTE_W  = 8;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_MOVE = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_UNDER = 2'd1;
    localparam logic [1:0] STATUS_OVER  = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [IDX_W-1:0]   stack_from;
        logic [IDX_W-1:0]   stack_to;
        logic [COUNT_W-1:0] move_count;
        logic [BYTE_W-1:0]  crate;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] top_value;
        logic [1:0]        status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FROM,
        ST_RD_TO,
        ST_CHECK,
        ST_POP_CAP,
        ST_MOVE,
        ST_UPD_TO,
        ST_UPD_FROM,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/msbm_ram.sv =====
// ----------------------------------------------------------------------------
// msbm_ram : generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module msbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 576
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/msbm_heights.sv =====
// ----------------------------------------------------------------------------
// msbm_heights : per-stack fill heights
// Flop array cleared on reset, one read and one write index.
// Indexes outside the stack range read as zero.
// ----------------------------------------------------------------------------
module msbm_heights #(
    parameter int STACK_COUNT = msbm_pkg::STACK_COUNT_DEF,
    parameter int STACK_DEPTH = msbm_pkg::STACK_DEPTH_DEF,
    localparam int HW  = $clog2(STACK_DEPTH + 1),
    localparam int SIW = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [msbm_pkg::IDX_W-1:0] rd_idx,
    output logic [HW-1:0]              rd_height,
    input  logic                       wr_en,
    input  logic [msbm_pkg::IDX_W-1:0] wr_idx,
    input  logic [HW-1:0]              wr_height
);

    logic [HW-1:0] height_reg [STACK_COUNT];
    logic          rd_in_range;
    logic          wr_in_range;
    logic [SIW-1:0] rd_sel;
    logic [SIW-1:0] wr_sel;

    assign rd_in_range = {1'b0, rd_idx} < (msbm_pkg::IDX_W + 1)'(STACK_COUNT);
    assign wr_in_range = {1'b0, wr_idx} < (msbm_pkg::IDX_W + 1)'(STACK_COUNT);
    assign rd_sel      = rd_idx[SIW-1:0];
    assign wr_sel      = wr_idx[SIW-1:0];

    assign rd_height = rd_in_range ? height_reg[rd_sel] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STACK_COUNT; i++) begin
                height_reg[i] <= '0;
            end
        end else if (wr_en && wr_in_range) begin
            height_reg[wr_sel] <= wr_height;
        end
    end

endmodule

// ===== hdl/multi_stack_block_mover.sv =====
// ----------------------------------------------------------------------------
// multi_stack_block_mover : several byte stacks sharing one store
// Push, pop and multi-entry move commands with underflow/overflow flags.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one command transaction (push, pop or move). s_ready is high
//     only while the block is idle; a command is worked to completion first.
//   m_* channel: exactly one result transaction per command (popped byte and
//     status). m_valid holds with stable data until m_ready is seen; the
//     block takes no new command while a result waits.
//   cfg_* channel: crane_mode write, always ready. Write only while idle.
// Sequence: command accept, source height read, destination height read,
//   check, then result. Push, failed and no-op commands take this path.
//   successful pop: adds the POP_CAP state for the registered store read.
//   move: copy loop, then height updates. The copy loop streams one entry per
//     cycle through the single store: read of entry j overlaps the write of
//     entry j-1, so the RAM port pair sets the move rate.
// Throughput: one command at a time; s_ready returns the cycle after the
//   result transaction, so a stalled receiver holds off the next command.
// Reset (synchronous, aresetn low): all stack heights clear to zero,
//   crane_mode returns to 1 (block move), sequencer to idle. Store contents
//   are not cleared; only slots below a stack's height are ever read.
// ----------------------------------------------------------------------------
module multi_stack_block_mover #(
    parameter int STACK_COUNT = msbm_pkg::STACK_COUNT_DEF,
    parameter int STACK_DEPTH = msbm_pkg::STACK_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // command transactions
    input  logic                s_valid,
    output logic                s_ready,
    input  msbm_pkg::in_item_t  s_data,
    // result transactions
    output logic                m_valid,
    input  logic                m_ready,
    output msbm_pkg::out_item_t m_data,
    // configuration
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    localparam int SLOTS = STACK_COUNT * STACK_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int HW    = $clog2(STACK_DEPTH + 1);
    // compare width: covers both move_count and heights, plus headroom
    localparam int CW    = ((HW > msbm_pkg::COUNT_W) ? HW : msbm_pkg::COUNT_W) + 1;

    msbm_pkg::state_t    state_reg, state_next;
    msbm_pkg::in_item_t  cmd_reg, cmd_next;
    msbm_pkg::out_item_t result_reg, result_next;
    logic                crane_mode_reg;

    logic [HW-1:0] hf_reg, hf_next;          // source height (0 if out of range)
    logic [HW-1:0] ht_reg, ht_next;          // destination height
    logic          to_ok_reg, to_ok_next;    // destination index in range
    logic [AW-1:0] from_base_reg, from_base_next;
    logic [AW-1:0] to_base_reg, to_base_next;
    logic [AW-1:0] src_addr_reg, src_addr_next;
    logic [AW-1:0] dst_addr_reg, dst_addr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // height file ports
    logic [msbm_pkg::IDX_W-1:0] h_rd_idx;
    logic [HW-1:0]              h_rd_height;
    logic                       h_wr_en;
    logic [msbm_pkg::IDX_W-1:0] h_wr_idx;
    logic [HW-1:0]              h_wr_height;

    // store ports
    logic                     ram_wr_en;
    logic [AW-1:0]            ram_wr_addr;
    logic [msbm_pkg::BYTE_W-1:0] ram_wr_data;
    logic                     ram_rd_en;
    logic [AW-1:0]            ram_rd_addr;
    logic [msbm_pkg::BYTE_W-1:0] ram_rd_data;

    // decode helpers
    logic [CW-1:0] n_cw, hf_cw, room_cw;
    logic          to_in_range;
    logic [HW-1:0] src_off;

    assign n_cw    = CW'(cmd_reg.move_count);
    assign hf_cw   = CW'(hf_reg);
    assign room_cw = to_ok_reg ? (CW'(STACK_DEPTH) - CW'(ht_reg)) : '0;
    assign to_in_range = {1'b0, cmd_reg.stack_to} < (msbm_pkg::IDX_W + 1)'(STACK_COUNT);
    // block mode starts at the lowest moved entry, single mode at the top
    assign src_off = crane_mode_reg ? (hf_reg - HW'(cmd_reg.move_count))
                                    : (hf_reg - HW'(1));

    msbm_heights #(
        .STACK_COUNT (STACK_COUNT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_heights (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_idx    (h_rd_idx),
        .rd_height (h_rd_height),
        .wr_en     (h_wr_en),
        .wr_idx    (h_wr_idx),
        .wr_height (h_wr_height)
    );

    msbm_ram #(
        .WIDTH (msbm_pkg::BYTE_W),
        .DEPTH (SLOTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready   = (state_reg == msbm_pkg::ST_IDLE);
    assign m_valid   = (state_reg == msbm_pkg::ST_DONE);
    assign m_data    = result_reg;
    assign cfg_ready = 1'b1;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= msbm_pkg::ST_IDLE;
            crane_mode_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                crane_mode_reg <= cfg_data;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        result_reg    <= result_next;
        hf_reg        <= hf_next;
        ht_reg        <= ht_next;
        to_ok_reg     <= to_ok_next;
        from_base_reg <= from_base_next;
        to_base_reg   <= to_base_next;
        src_addr_reg  <= src_addr_next;
        dst_addr_reg  <= dst_addr_next;
        cnt_reg       <= cnt_next;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        result_next    = result_reg;
        hf_next        = hf_reg;
        ht_next        = ht_reg;
        to_ok_next     = to_ok_reg;
        from_base_next = from_base_reg;
        to_base_next   = to_base_reg;
        src_addr_next  = src_addr_reg;
        dst_addr_next  = dst_addr_reg;
        cnt_next       = cnt_reg;

        h_rd_idx    = cmd_reg.stack_from;
        h_wr_en     = 1'b0;
        h_wr_idx    = cmd_reg.stack_to;
        h_wr_height = ht_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = dst_addr_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = src_addr_reg;

        case (state_reg)
            msbm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data;
                    state_next = msbm_pkg::ST_RD_FROM;
                end
            end

            msbm_pkg::ST_RD_FROM: begin
                h_rd_idx       = cmd_reg.stack_from;
                hf_next        = h_rd_height;
                from_base_next = AW'(32'(cmd_reg.stack_from) * STACK_DEPTH);
                state_next     = msbm_pkg::ST_RD_TO;
            end

            msbm_pkg::ST_RD_TO: begin
                h_rd_idx     = cmd_reg.stack_to;
                ht_next      = h_rd_height;
                to_ok_next   = to_in_range;
                to_base_next = AW'(32'(cmd_reg.stack_to) * STACK_DEPTH);
                state_next   = msbm_pkg::ST_CHECK;
            end

            msbm_pkg::ST_CHECK: begin
                result_next.top_value = '0;
                result_next.status    = msbm_pkg::STATUS_OK;
                state_next            = msbm_pkg::ST_DONE;
                case (cmd_reg.command)
                    msbm_pkg::CMD_PUSH: begin
                        if (room_cw == '0) begin
                            result_next.status = msbm_pkg::STATUS_OVER;
                        end else begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = to_base_reg + AW'(ht_reg);
                            ram_wr_data = cmd_reg.crate;
                            h_wr_en     = 1'b1;
                            h_wr_idx    = cmd_reg.stack_to;
                            h_wr_height = ht_reg + HW'(1);
                        end
                    end
                    msbm_pkg::CMD_POP: begin
                        if (hf_reg == '0) begin
                            result_next.status = msbm_pkg::STATUS_UNDER;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = from_base_reg + AW'(hf_reg - HW'(1));
                            h_wr_en     = 1'b1;
                            h_wr_idx    = cmd_reg.stack_from;
                            h_wr_height = hf_reg - HW'(1);
                            state_next  = msbm_pkg::ST_POP_CAP;
                        end
                    end
                    msbm_pkg::CMD_MOVE: begin
                        if (n_cw == '0) begin
                            result_next.status = msbm_pkg::STATUS_OK;
                        end else if (n_cw > hf_cw) begin
                            result_next.status = msbm_pkg::STATUS_UNDER;
                        end else if (cmd_reg.stack_from == cmd_reg.stack_to) begin
                            result_next.status = msbm_pkg::STATUS_OK;
                        end else if (n_cw > room_cw) begin
                            result_next.status = msbm_pkg::STATUS_OVER;
                        end else begin
                            src_addr_next = from_base_reg + AW'(src_off);
                            dst_addr_next = to_base_reg + AW'(ht_reg);
                            cnt_next      = '0;
                            state_next    = msbm_pkg::ST_MOVE;
                        end
                    end
                    default: begin
                        result_next.status = msbm_pkg::STATUS_OK;
                    end
                endcase
            end

            msbm_pkg::ST_POP_CAP: begin
                result_next.top_value = ram_rd_data;
                state_next            = msbm_pkg::ST_DONE;
            end

            // read of entry cnt overlaps write of entry cnt-1
            msbm_pkg::ST_MOVE: begin
                if (cnt_reg != n_cw) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = src_addr_reg;
                    src_addr_next = crane_mode_reg ? (src_addr_reg + AW'(1))
                                                   : (src_addr_reg - AW'(1));
                end
                if (cnt_reg != '0) begin
                    ram_wr_en     = 1'b1;
                    ram_wr_addr   = dst_addr_reg;
                    ram_wr_data   = ram_rd_data;
                    dst_addr_next = dst_addr_reg + AW'(1);
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == n_cw) begin
                    state_next = msbm_pkg::ST_UPD_TO;
                end
            end

            msbm_pkg::ST_UPD_TO: begin
                h_wr_en     = 1'b1;
                h_wr_idx    = cmd_reg.stack_to;
                h_wr_height = ht_reg + HW'(cmd_reg.move_count);
                state_next  = msbm_pkg::ST_UPD_FROM;
            end

            msbm_pkg::ST_UPD_FROM: begin
                h_wr_en     = 1'b1;
                h_wr_idx    = cmd_reg.stack_from;
                h_wr_height = hf_reg - HW'(cmd_reg.move_count);
                state_next  = msbm_pkg::ST_DONE;
            end

            msbm_pkg::ST_DONE: begin
                if (m_ready) begin
                    state_next = msbm_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = msbm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/msbm_checker.sv =====
// ----------------------------------------------------------------------------
// msbm_checker : port-level checks for the multi-stack block mover
// Bound to the top level; watches the command and result channels.
// ----------------------------------------------------------------------------
module msbm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input msbm_pkg::out_item_t m_data
);

    // one command in flight: never ready for a command while a result waits
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("command accepted while result pending");

    // a result never appears in the cycle right after a command is taken
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid)
        else $error("result too early");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped or changed under stall");

    // failed commands report no byte and carry a defined failure code
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != msbm_pkg::STATUS_OK)) |->
            ((m_data.top_value == '0) &&
             ((m_data.status == msbm_pkg::STATUS_UNDER) ||
              (m_data.status == msbm_pkg::STATUS_OVER))))
        else $error("bad result on failed command");

endmodule

bind multi_stack_block_mover msbm_checker u_msbm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
